// ===== design/ita_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ita_pkg;

  // digit positions in the converter shift line: 22 octal digits cover 64 bits
  localparam int NUM_POS = 22;
  localparam int DIG_W = 4 * NUM_POS;
  localparam int REM_W = $clog2(NUM_POS + 1);
  localparam int VAL_W = 64;
  localparam int BCD_DIGITS = 20;
  localparam int BCD_W = 4 * BCD_DIGITS;
  // two bits shifted in per cycle
  localparam int DABBLE_CYCLES = VAL_W / 2;
  localparam int DAB_CNT_W = $clog2(DABBLE_CYCLES);
  localparam int CHAR_W = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;

  localparam logic [1:0] RADIX_OCT = 2'd0;
  localparam logic [1:0] RADIX_DEC = 2'd1;

  typedef enum logic [1:0] {
    BASE_OCT,
    BASE_DEC,
    BASE_HEX
  } base_t;

  typedef struct packed {
    logic [VAL_W-1:0] mag;
    logic             neg;
    base_t            base;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } back_state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = CHAR_LOWER_A + {3'b000, d - 4'd10};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/integer_to_radix_ascii_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// flow: the back pops a queued transaction when idle and loads the digit shift line;
//   decimal first runs double-dabble (two bits a cycle), then leading zeros shift out
// the 22-position digit shift line steps once a cycle, while emitting only when the output
//   register can load; a '-' goes first for a negative value; one number converts at a time
// a two-entry queue lets the next transaction be taken while a number is converted
// reset: synchronous active-low rst_n empties the queue and output register, back goes idle
module integer_to_radix_ascii_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [63:0]           in_value,
  input  wire logic                  in_mode,
  input  wire logic [1:0]            in_radix,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [6:0]                 out_char_code,
  output logic                       out_last
);
  import ita_pkg::*;

  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic pop_valid;
  job_t pop_job;

  ita_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .in_mode  (in_mode),
    .in_radix (in_radix),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  ita_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_job   (pop_job)
  );

  ita_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (pop_valid),
    .q_job         (pop_job),
    .q_pop         (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

// ===== design/ita_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ita_front (
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [63:0]                 in_value,
  input  wire logic                        in_mode,
  input  wire logic [1:0]                  in_radix,
  input  wire logic                        q_full,
  output logic                             push,
  output ita_pkg::job_t                    push_job
);
  import ita_pkg::*;

  logic neg;

  assign neg = in_mode & in_value[VAL_W-1];
  assign in_stall = q_full;
  assign push = in_valid && !q_full;

  always_comb begin
    push_job.neg = neg;
    // unsigned negation, so the most negative value becomes 2^63
    push_job.mag = neg ? (~in_value + VAL_W'(1)) : in_value;
    case (in_radix)
      RADIX_OCT: push_job.base = BASE_OCT;
      RADIX_DEC: push_job.base = BASE_DEC;
      default:   push_job.base = BASE_HEX;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/ita_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ita_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ita_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               pop_valid,
  output ita_pkg::job_t      pop_job
);
  import ita_pkg::*;

  job_t                mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_pop;

  assign full = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_job = mem_r[rd_ptr_r];
  assign do_pop = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ===== design/ita_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ita_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire ita_pkg::job_t               q_job,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ita_pkg::CHAR_W-1:0]       out_char_code,
  output logic                             out_last
);
  import ita_pkg::*;

  back_state_t            state_r, state_nxt;
  logic [DIG_W-1:0]       digs_r, digs_nxt;
  logic [VAL_W-1:0]       mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [DAB_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   can_load;
  logic                   top_zero;
  logic                   load_out;

  // one shift-and-add-3 step over the bcd digits and the remaining binary bits
  function automatic logic [BCD_W+VAL_W-1:0] dabble_step(input logic [BCD_W+VAL_W-1:0] x);
    logic [BCD_W+VAL_W-1:0] y;
    logic [3:0]             nib;
    y = x;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      nib = y[VAL_W + 4*k +: 4];
      if (nib >= 4'd5) begin
        y[VAL_W + 4*k +: 4] = nib + 4'd3;
      end
    end
    return {y[BCD_W+VAL_W-2:0], 1'b0};
  endfunction

  assign can_load = !out_valid_r || !out_stall;
  assign top_zero = (digs_r[DIG_W-1 -: 4] == 4'd0);
  assign q_pop = (state_r == ST_IDLE) && q_valid;
  assign load_out = can_load && ((state_r == ST_SIGN) || (state_r == ST_EMIT));

  assign out_valid = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last = out_last_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_job.base == BASE_DEC) ? ST_DABBLE : ST_SKIP;
        end
      end
      ST_DABBLE: begin
        if (cnt_r == DAB_CNT_W'(DABBLE_CYCLES - 1)) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!(top_zero && rem_r > REM_W'(1))) begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (can_load) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_load && rem_r == REM_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    logic [BCD_W+VAL_W-1:0] dab;
    logic [VAL_W+1:0]       oct_pad;
    digs_nxt = digs_r;
    mag_nxt = mag_r;
    neg_nxt = neg_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    dab = '0;
    oct_pad = {2'b00, q_job.mag};
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          mag_nxt = q_job.mag;
          neg_nxt = q_job.neg;
          rem_nxt = REM_W'(NUM_POS);
          cnt_nxt = '0;
          case (q_job.base)
            BASE_OCT: begin
              for (int j = 0; j < NUM_POS; j++) begin
                digs_nxt[4*j +: 4] = {1'b0, oct_pad[3*j +: 3]};
              end
            end
            BASE_HEX: digs_nxt = {(DIG_W - VAL_W)'(0), q_job.mag};
            default:  digs_nxt = '0;
          endcase
        end
      end
      ST_DABBLE: begin
        dab = dabble_step(dabble_step({digs_r[BCD_W-1:0], mag_r}));
        digs_nxt = {(DIG_W - BCD_W)'(0), dab[BCD_W+VAL_W-1:VAL_W]};
        mag_nxt = dab[VAL_W-1:0];
        cnt_nxt = cnt_r + DAB_CNT_W'(1);
      end
      ST_SKIP: begin
        // drop leading zero positions, keeping at least one digit
        if (top_zero && rem_r > REM_W'(1)) begin
          digs_nxt = {digs_r[DIG_W-5:0], 4'd0};
          rem_nxt = rem_r - REM_W'(1);
        end
      end
      ST_SIGN: begin
        if (can_load) begin
          out_char_nxt = CHAR_MINUS;
          out_last_nxt = 1'b0;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          out_char_nxt = digit_char(digs_r[DIG_W-1 -: 4]);
          out_last_nxt = (rem_r == REM_W'(1));
          digs_nxt = {digs_r[DIG_W-5:0], 4'd0};
          rem_nxt = rem_r - REM_W'(1);
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      rem_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digs_r <= digs_nxt;
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef SYNTHESIS
  // bcd of a 64-bit value fits in twenty digits
  a_bcd_fits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DABBLE |-> digs_r[DIG_W-1:BCD_W] == '0)
    else $error("bcd conversion spilled past twenty digits");

  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SKIP || state_r == ST_EMIT) |-> rem_r != '0)
    else $error("digit count ran out while converting");

  a_last_ends_number: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && state_r == ST_EMIT && rem_r == REM_W'(1)) |=> state_r == ST_IDLE)
    else $error("final character did not end the number");

  a_sign_before_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SIGN) |-> neg_r)
    else $error("sign emitted for a non-negative value");
`endif

endmodule

`default_nettype wire

// ===== bench/integer_to_radix_ascii_core_tb.sv =====
`timescale 1ns / 1ps

module integer_to_radix_ascii_core_tb;
  import ita_pkg::*;

  localparam logic       MODE_UNSIGNED = 1'b0;
  localparam logic       MODE_SIGNED = 1'b1;
  localparam logic [1:0] RADIX_HEX = 2'd2;
  localparam logic [1:0] RADIX_HEX_ALT = 2'd3;
  localparam int         IDLE_PCT = 35;
  localparam int         SETTLE_CYCLES = 120;
  localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } ascii_char_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [63:0]       in_value = '0;
  logic              in_mode = 1'b0;
  logic [1:0]        in_radix = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [6:0]        out_char_code;
  logic              out_last;

  ascii_char_t       expected_chars[$];
  int                mismatch_count = 0;
  bit                send_idle_en = 1'b0;
  bit                recv_stall_en = 1'b0;

  integer_to_radix_ascii_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_mode       (in_mode),
    .in_radix      (in_radix),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** integer_to_radix_ascii_core: FAILED **");
    $finish;
  end

  function automatic logic [CHAR_W-1:0] ascii_of_digit(input logic [3:0] d);
    if (d < 4'd10) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return CHAR_LOWER_A + CHAR_W'(d) - CHAR_W'(10);
  endfunction

  // queue the characters one number turns into, sign first, most significant digit next
  function automatic void predict_digits(input logic [63:0] value, input logic mode,
                                         input logic [1:0] radix);
    logic [63:0] mag;
    logic [63:0] base;
    logic [63:0] rem;
    logic [3:0]  digits[$];
    logic        neg;
    case (radix)
      RADIX_OCT: base = 64'd8;
      RADIX_DEC: base = 64'd10;
      default:   base = 64'd16;
    endcase
    neg = (mode == MODE_SIGNED) && value[63];
    mag = neg ? (64'd0 - value) : value;
    do begin
      rem = mag % base;
      digits.push_back(rem[3:0]);
      mag = mag / base;
    end while (mag != 64'd0);
    if (neg) begin
      expected_chars.push_back('{code: CHAR_MINUS, last: 1'b0});
    end
    for (int i = digits.size() - 1; i >= 0; i--) begin
      expected_chars.push_back('{code: ascii_of_digit(digits[i]), last: (i == 0)});
    end
  endfunction

  function automatic void note_mismatch(input string what);
    if (mismatch_count < 10) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    mismatch_count++;
  endfunction

  always @(posedge clk) begin
    out_stall <= recv_stall_en && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // result checker: every character transaction against the oldest expectation
  always @(posedge clk) begin
    ascii_char_t exp_char;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        note_mismatch($sformatf("unexpected char 0x%02h last %0b", out_char_code, out_last));
      end else begin
        exp_char = expected_chars.pop_front();
        if (out_char_code !== exp_char.code) begin
          note_mismatch($sformatf("char_code expected 0x%02h actual 0x%02h",
                                  exp_char.code, out_char_code));
        end
        if (out_last !== exp_char.last) begin
          note_mismatch($sformatf("last expected %0b actual %0b (char 0x%02h)",
                                  exp_char.last, out_last, exp_char.code));
        end
      end
    end
  end

  // valid stays high across back-to-back transactions; lowered only on idle cycles
  task automatic send_number(input logic [63:0] value, input logic mode,
                             input logic [1:0] radix);
    while (send_idle_en && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    in_mode  <= mode;
    in_radix <= radix;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_digits(value, mode, radix);
  endtask

  task automatic wait_all_chars();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [63:0] random_value();
    case ($urandom_range(0, 5))
      0:       return 64'($urandom_range(0, 999));
      1:       return 64'd1 << $urandom_range(0, 63);
      2:       return ALL_ONES - 64'($urandom_range(0, 15));
      3:       return MOST_NEG + 64'($urandom_range(0, 15));
      4:       return 64'({$urandom, $urandom}) >> $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_directed();
    send_idle_en  = 1'b1;
    recv_stall_en = 1'b1;
    // zero in every radix code and both modes
    for (int r = 0; r < 4; r++) begin
      send_number(64'd0, MODE_UNSIGNED, 2'(r));
      send_number(64'd0, MODE_SIGNED, 2'(r));
    end
    send_number(64'd1, MODE_SIGNED, RADIX_DEC);
    send_number(ALL_ONES, MODE_UNSIGNED, RADIX_OCT);
    send_number(ALL_ONES, MODE_UNSIGNED, RADIX_DEC);
    send_number(ALL_ONES, MODE_UNSIGNED, RADIX_HEX);
    send_number(ALL_ONES, MODE_SIGNED, RADIX_DEC);
    // most negative value in each base, and the same bits read unsigned in decimal
    send_number(MOST_NEG, MODE_SIGNED, RADIX_OCT);
    send_number(MOST_NEG, MODE_SIGNED, RADIX_DEC);
    send_number(MOST_NEG, MODE_SIGNED, RADIX_HEX);
    send_number(MOST_NEG, MODE_UNSIGNED, RADIX_DEC);
    send_number(MOST_NEG - 64'd1, MODE_SIGNED, RADIX_DEC);
    send_number(64'h0123_4567_89ab_cdef, MODE_UNSIGNED, RADIX_HEX_ALT);
    send_number(64'hfedc_ba98_7654_3210, MODE_UNSIGNED, RADIX_HEX_ALT);
    send_number(64'd0 - 64'd10, MODE_SIGNED, RADIX_DEC);
    send_number(64'd9, MODE_UNSIGNED, RADIX_DEC);
    send_number(64'd10, MODE_UNSIGNED, RADIX_DEC);
    send_number(64'd8, MODE_SIGNED, RADIX_OCT);
  endtask

  task automatic test_random_mixed();
    send_idle_en  = 1'b1;
    recv_stall_en = 1'b1;
    repeat (36) begin
      send_number(random_value(), 1'($urandom), 2'($urandom));
    end
  endtask

  task automatic test_pause_until_drained();
    send_idle_en  = 1'b1;
    recv_stall_en = 1'b1;
    repeat (10) begin
      send_number(random_value(), 1'($urandom), 2'($urandom));
    end
    wait_all_chars();
    repeat (10) begin
      send_number(random_value(), 1'($urandom), 2'($urandom));
    end
  endtask

  task automatic test_back_to_back();
    send_idle_en  = 1'b0;
    recv_stall_en = 1'b0;
    repeat (30) begin
      send_number({$urandom, $urandom}, 1'($urandom), 2'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mixed();
    test_pause_until_drained();
    test_back_to_back();
    recv_stall_en = 1'b1;
    wait_all_chars();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0) begin
      note_mismatch($sformatf("%0d chars never arrived", expected_chars.size()));
    end
    if (mismatch_count == 0) begin
      $display("** integer_to_radix_ascii_core: PASSED **");
    end else begin
      $display("** integer_to_radix_ascii_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ita_pkg.sv
design/ita_front.sv
design/ita_queue.sv
design/ita_back.sv
design/integer_to_radix_ascii_core.sv
bench/integer_to_radix_ascii_core_tb.sv
